// ===== design/skip_list_sorted_set_core_macros.svh =====
// Assertion macros for the skip list sorted set core checker.
`ifndef SKIP_LIST_SORTED_SET_CORE_MACROS_SVH
`define SKIP_LIST_SORTED_SET_CORE_MACROS_SVH
// Check a same-cycle implication, sampled at clk and idle during rst.
`define SLS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Check a next-cycle implication, sampled at clk and idle during rst.
`define SLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

// ===== design/sls_pkg.sv =====
// Shared constants, state codes and control structs for the skip list core.
package sls_pkg;

  localparam int POOL_NODES_DEF = 256;
  localparam int MAX_HEIGHT_DEF = 7;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_NEXT, S_NWAIT, S_KWAIT, S_COIN, S_POPRD, S_POP,
    S_LINK0, S_LINK1, S_LINK2, S_DEL0, S_DEL1, S_DEL2,
    S_FREE, S_LOWER, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SRC_X, SRC_UPD, SRC_C
  } rd_src_t;

  typedef struct packed {
    logic    init;
    logic    rd_en;
    rd_src_t rd_src;
    logic    n_cap;
    logic    adv;
    logic    down;
    logic    walk_end;
    logic    set_full;
    logic    coin;
    logic    pop;
    logic    lk_wnew;
    logic    lk_wupd;
    logic    i_inc;
    logic    set_top;
    logic    d_wupd;
    logic    push;
    logic    top_sel;
    logic    lower;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       op_bad;
    logic       less;
    logic       hit;
    logic       lvl_zero;
    logic       pool_empty;
    logic       coin_stop;
    logic       i_at_h;
    logic       v_eq_c;
    logic       i_at_top;
    logic       lower_ok;
  } status_t;

endpackage

// ===== design/sls_ctrl.sv =====
// Controller state machine sequencing walk, insert, delete and free-list steps.
module sls_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  sls_pkg::status_t st,
  output sls_pkg::cmd_t   cmd,
  output logic            busy,
  output logic            done
);
  import sls_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_NEXT;
      end
      S_NEXT: begin
        state_next = st.op_bad ? S_DONE : S_NWAIT;
      end
      S_NWAIT: state_next = S_KWAIT;
      S_KWAIT: begin
        if (st.less || !st.lvl_zero) begin
          state_next = S_NEXT;
        end else if (st.op == OP_INSERT && !st.hit) begin
          state_next = st.pool_empty ? S_DONE : S_COIN;
        end else if (st.op == OP_DELETE && st.hit) begin
          state_next = S_DEL0;
        end else begin
          state_next = S_DONE;
        end
      end
      S_COIN: begin
        if (st.coin_stop) state_next = S_POPRD;
      end
      S_POPRD: state_next = S_POP;
      S_POP:   state_next = S_LINK0;
      S_LINK0: state_next = S_LINK1;
      S_LINK1: state_next = S_LINK2;
      S_LINK2: state_next = st.i_at_h ? S_DONE : S_LINK0;
      S_DEL0:  state_next = S_DEL1;
      S_DEL1:  state_next = st.v_eq_c ? S_DEL2 : S_FREE;
      S_DEL2:  state_next = st.i_at_top ? S_FREE : S_DEL0;
      S_FREE:  state_next = S_LOWER;
      S_LOWER: begin
        if (!st.lower_ok) state_next = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_src = SRC_X;
    case (state)
      S_IDLE: cmd.init = start;
      S_NEXT: begin
        cmd.rd_en = !st.op_bad;
      end
      S_NWAIT: cmd.n_cap = 1'b1;
      S_KWAIT: begin
        if (st.less) begin
          cmd.adv = 1'b1;
        end else if (!st.lvl_zero) begin
          cmd.down = 1'b1;
        end else begin
          cmd.walk_end = 1'b1;
          cmd.set_full = (st.op == OP_INSERT) && !st.hit && st.pool_empty;
        end
      end
      S_COIN: cmd.coin = 1'b1;
      S_POP:  cmd.pop = 1'b1;
      S_LINK0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = SRC_UPD;
      end
      S_LINK1: cmd.lk_wnew = 1'b1;
      S_LINK2: begin
        cmd.lk_wupd = 1'b1;
        cmd.set_top = st.i_at_h;
        cmd.i_inc   = !st.i_at_h;
      end
      S_DEL0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = SRC_UPD;
      end
      S_DEL1: begin
        cmd.rd_en  = st.v_eq_c;
        cmd.rd_src = SRC_C;
      end
      S_DEL2: begin
        cmd.d_wupd = 1'b1;
        cmd.i_inc  = !st.i_at_top;
      end
      S_FREE: cmd.push = 1'b1;
      S_LOWER: begin
        cmd.top_sel = 1'b1;
        cmd.lower   = st.lower_ok;
      end
      default: cmd = '0;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ===== design/sls_dp.sv =====
// Datapath: node pool memories, head pointers, free stack, coin LFSR, walk registers.
module sls_dp #(
  parameter int POOL_NODES = sls_pkg::POOL_NODES_DEF,
  parameter int MAX_HEIGHT = sls_pkg::MAX_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sls_pkg::cmd_t       cmd,
  input  logic [1:0]          op,
  input  logic signed [31:0]  key,
  output sls_pkg::status_t    st,
  output logic                found,
  output logic                pool_full
);
  import sls_pkg::*;

  localparam int LEVELS = MAX_HEIGHT + 1;
  localparam int NW = $clog2(POOL_NODES);
  localparam int PW = $clog2(POOL_NODES + 2);
  localparam int LW = (MAX_HEIGHT > 0) ? $clog2(MAX_HEIGHT + 1) : 1;
  localparam int CW = $clog2(POOL_NODES + 1);
  localparam int AW = NW + LW;
  localparam logic [PW-1:0] NIL   = PW'(POOL_NODES);
  localparam logic [PW-1:0] HEADP = PW'(POOL_NODES + 1);
  localparam logic [LW-1:0] LVL_MAX = LW'(MAX_HEIGHT);
  localparam logic [CW-1:0] CNT_FULL = CW'(POOL_NODES);
  localparam logic [CW-1:0] CNT_LAST = CW'(POOL_NODES - 1);

  logic [31:0]        key_mem [POOL_NODES];
  logic [PW-1:0]      next_mem [2**AW];
  logic [NW-1:0]      free_mem [POOL_NODES];

  logic [1:0]         op_r;
  logic signed [31:0] key_r;
  logic [LW-1:0]      lvl, i, h, top, rd_lvl;
  logic [PW-1:0]      x, n, c, nn_p;
  logic [PW-1:0]      upd [LEVELS];
  logic [PW-1:0]      head [LEVELS];
  logic [15:0]        lfsr;
  logic [CW-1:0]      free_count, min_count;
  logic [NW-1:0]      nn;
  logic               rd_head;
  logic [PW-1:0]      nx_q;
  logic signed [31:0] key_rq;
  logic [NW-1:0]      free_q;

  logic [PW-1:0]      upd_i, upd_eff, rd_ptr, head_rd, nx_val;
  logic [LW-1:0]      rd_lvl_sel, head_addr;
  logic [CW-1:0]      pc;
  logic [NW-1:0]      nn_cmb;
  logic               wen;
  logic [AW-1:0]      waddr;
  logic [PW-1:0]      wdata;

  assign upd_i   = upd[i];
  assign upd_eff = (i > top) ? HEADP : upd_i;

  always_comb begin
    case (cmd.rd_src)
      SRC_X:   begin rd_ptr = x;       rd_lvl_sel = lvl; end
      SRC_UPD: begin rd_ptr = upd_eff; rd_lvl_sel = i;   end
      SRC_C:   begin rd_ptr = c;       rd_lvl_sel = i;   end
      default: begin rd_ptr = x;       rd_lvl_sel = lvl; end
    endcase
  end

  assign head_addr = cmd.top_sel ? top : rd_lvl;
  assign head_rd   = head[head_addr];
  assign nx_val    = rd_head ? head_rd : nx_q;

  assign pc     = free_count - CW'(1);
  assign nn_cmb = (pc < min_count) ? NW'(CNT_LAST - pc) : free_q;
  assign nn_p   = PW'(nn);

  always_comb begin
    wen   = 1'b0;
    waddr = {nn, i};
    wdata = nx_val;
    if (cmd.lk_wnew) begin
      wen = 1'b1;
    end else if (cmd.lk_wupd && upd_eff != HEADP) begin
      wen   = 1'b1;
      waddr = {upd_eff[NW-1:0], i};
      wdata = nn_p;
    end else if (cmd.d_wupd && upd_i != HEADP) begin
      wen   = 1'b1;
      waddr = {upd_i[NW-1:0], i};
      wdata = nx_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) next_mem[waddr] <= wdata;
    if (cmd.rd_en) begin
      nx_q    <= next_mem[{rd_ptr[NW-1:0], rd_lvl_sel}];
      rd_head <= (rd_ptr == HEADP);
      rd_lvl  <= rd_lvl_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) key_mem[nn_cmb] <= key_r;
    key_rq <= key_mem[nx_val[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.push && free_count < CNT_FULL) free_mem[free_count[NW-1:0]] <= c[NW-1:0];
    free_q <= free_mem[pc[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      op_r      <= op;
      key_r     <= key;
      lvl       <= top;
      x         <= HEADP;
      i         <= '0;
      h         <= '0;
      found     <= 1'b0;
      pool_full <= 1'b0;
    end
    if (cmd.n_cap) n <= nx_val;
    if (cmd.adv) x <= n;
    if (cmd.down) begin
      upd[lvl] <= x;
      lvl      <= lvl - LW'(1);
    end
    if (cmd.walk_end) begin
      upd[lvl] <= x;
      c        <= n;
      found    <= st.hit;
    end
    if (cmd.set_full) pool_full <= 1'b1;
    if (cmd.coin && lfsr[0] && h != LVL_MAX) h <= h + LW'(1);
    if (cmd.pop) nn <= nn_cmb;
    if (cmd.i_inc) i <= i + LW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LEVELS; k++) head[k] <= NIL;
      top        <= '0;
      free_count <= CNT_FULL;
      min_count  <= CNT_FULL;
      lfsr       <= LFSR_SEED;
    end else begin
      if (cmd.coin) lfsr <= (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
      if (cmd.pop) begin
        free_count <= pc;
        if (pc < min_count) min_count <= pc;
      end
      if (cmd.push && free_count < CNT_FULL) free_count <= free_count + CW'(1);
      if (cmd.lk_wupd && upd_eff == HEADP) head[i] <= nn_p;
      if (cmd.d_wupd && upd_i == HEADP) head[i] <= nx_val;
      if (cmd.set_top && h > top) top <= h;
      if (cmd.lower) top <= top - LW'(1);
    end
  end

  always_comb begin
    st.op         = op_r;
    st.op_bad     = (op_r == OP_NONE);
    st.less       = (n != NIL) && (key_rq < key_r);
    st.hit        = (n != NIL) && (key_rq == key_r);
    st.lvl_zero   = (lvl == '0);
    st.pool_empty = (free_count == '0);
    st.coin_stop  = !lfsr[0] || (h == LVL_MAX);
    st.i_at_h     = (i == h);
    st.v_eq_c     = (nx_val == c);
    st.i_at_top   = (i == top);
    st.lower_ok   = (top != '0) && (head_rd == NIL);
  end

endmodule

// ===== design/skip_list_sorted_set_core.sv =====
// Skip list sorted set core: insert, delete and search of signed 32-bit keys.
// From accept to done the walk reads each visited node and steps down each level; insert
// then flips coins, pops a node and links each new level; delete unlinks each level that
// still points at the node, pushes the node back and lowers the empty top levels.
// Done is high one cycle and start is taken in the cycle after it: no new beat is taken until done.
// Reset (rst, synchronous): empty set, full free list, LFSR at its seed.
module skip_list_sorted_set_core #(
  parameter int POOL_NODES = sls_pkg::POOL_NODES_DEF,
  parameter int MAX_HEIGHT = sls_pkg::MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         op,
  input  logic signed [31:0] key,
  output logic               busy,
  output logic               done,
  output logic               found,
  output logic               pool_full
);
  import sls_pkg::*;

  cmd_t    cmd;
  status_t st;

  sls_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .st   (st),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  sls_dp #(
    .POOL_NODES(POOL_NODES),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .op       (op),
    .key      (key),
    .st       (st),
    .found    (found),
    .pool_full(pool_full)
  );

endmodule

// ===== design/sls_checker.sv =====
// Port-level checker for the skip list core, bound to the top level.
`include "skip_list_sorted_set_core_macros.svh"
module sls_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic found,
  input logic pool_full
);
  `SLS_ASSERT_NOW(a_excl_flags, done, !(found && pool_full))
  `SLS_ASSERT_NOW(a_done_busy, done, busy)
  `SLS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SLS_ASSERT_NEXT(a_done_pulse, done, !done)
  `SLS_ASSERT_NEXT(a_done_idle, done, !busy)
endmodule

bind skip_list_sorted_set_core sls_checker u_sls_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .found    (found),
  .pool_full(pool_full)
);

// ===== tb/sv/skip_list_sorted_set_checker.sv =====
// Checker for the skip list sorted set core: predicts each result and compares.
`timescale 1ns / 1ps
module skip_list_sorted_set_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         op,
  input  logic signed [31:0] key,
  input  logic               busy,
  input  logic               done,
  input  logic               found,
  input  logic               pool_full,
  output int                 errors,
  output int                 pending
);
  import sls_pkg::*;

  localparam int NODES  = POOL_NODES_DEF;
  localparam int LEVELS = MAX_HEIGHT_DEF + 1;
  localparam int NIL    = NODES;
  localparam int HEAD   = NODES + 1;

  typedef struct packed {
    logic found;
    logic full;
  } set_result_t;

  logic [31:0] set_key  [NODES];
  int          set_link [NODES][LEVELS];
  int          head_link[LEVELS];
  int          set_top;
  int          free_stack[NODES];
  int          free_cnt;
  logic [15:0] coin_reg;
  set_result_t result_q[$];

  function automatic int link_of(int x, int lvl);
    if (x == HEAD) return head_link[lvl];
    return set_link[x][lvl];
  endfunction

  function automatic void link_set(int x, int lvl, int v);
    if (x == HEAD) head_link[lvl] = v;
    else set_link[x][lvl] = v;
  endfunction

  function automatic logic flip_coin();
    logic b;
    b = coin_reg[0];
    coin_reg = coin_reg >> 1;
    if (b) coin_reg = coin_reg ^ LFSR_TAPS;
    return b;
  endfunction

  function automatic void clear_set();
    for (int i = 0; i < LEVELS; i++) head_link[i] = NIL;
    for (int i = 0; i < NODES; i++) free_stack[i] = NODES - 1 - i;
    set_top  = 0;
    free_cnt = NODES;
    coin_reg = LFSR_SEED;
  endfunction

  function automatic set_result_t apply_op(logic [1:0] code, logic [31:0] k);
    set_result_t r;
    logic [31:0] bk;
    int          prev[LEVELS];
    int          x, n, c, lvl;
    r  = '0;
    bk = k ^ 32'h8000_0000;
    for (int i = 0; i < LEVELS; i++) prev[i] = HEAD;
    if (code == OP_NONE) return r;
    x = HEAD;
    for (int i = set_top; i >= 0; i--) begin
      n = link_of(x, i);
      while (n != NIL && set_key[n] < bk) begin
        x = n;
        n = link_of(x, i);
      end
      prev[i] = x;
    end
    c = link_of(x, 0);
    r.found = (c != NIL) && (set_key[c] == bk);
    if (code == OP_INSERT && !r.found) begin
      if (free_cnt == 0) begin
        r.full = 1'b1;
      end else begin
        lvl = 0;
        while (flip_coin() && lvl < MAX_HEIGHT_DEF) lvl++;
        if (lvl > set_top) begin
          for (int i = set_top + 1; i <= lvl; i++) prev[i] = HEAD;
          set_top = lvl;
        end
        free_cnt--;
        n = free_stack[free_cnt];
        set_key[n] = bk;
        for (int i = 0; i <= lvl; i++) begin
          link_set(n, i, link_of(prev[i], i));
          link_set(prev[i], i, n);
        end
      end
    end else if (code == OP_DELETE && r.found) begin
      for (int i = 0; i <= set_top; i++) begin
        if (link_of(prev[i], i) != c) break;
        link_set(prev[i], i, link_of(c, i));
      end
      free_stack[free_cnt] = c;
      free_cnt++;
      while (set_top > 0 && head_link[set_top] == NIL) set_top--;
    end
    return r;
  endfunction

  task automatic report(string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    clear_set();
  end

  always @(posedge clk) begin
    set_result_t exp_r;
    if (rst) begin
      clear_set();
      result_q.delete();
    end else begin
      if (done) begin
        if (result_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          exp_r = result_q.pop_front();
          if (found !== exp_r.found)
            report($sformatf("found got %b exp %b", found, exp_r.found));
          if (pool_full !== exp_r.full)
            report($sformatf("pool_full got %b exp %b", pool_full, exp_r.full));
        end
      end
      if (start && !busy) result_q.push_back(apply_op(op, key));
    end
    pending = result_q.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the skip list sorted set testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import sls_pkg::*;

  logic               clk;
  logic               rst;
  logic               start;
  logic [1:0]         op;
  logic signed [31:0] key;
  logic               busy, done, found, pool_full;
  int                 errors, pending;
  logic [31:0]        key_set[320];
  bit                 idle_on;

  skip_list_sorted_set_core u_top (
    .clk(clk), .rst(rst), .start(start), .op(op), .key(key),
    .busy(busy), .done(done), .found(found), .pool_full(pool_full)
  );

  skip_list_sorted_set_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .op(op), .key(key),
    .busy(busy), .done(done), .found(found), .pool_full(pool_full),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_beat(logic [1:0] code, logic [31:0] k);
    start = 1'b1;
    op    = code;
    key   = k;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      op    = 2'($urandom);
      key   = $urandom;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_set[$urandom_range(0, 319)];
  endfunction

  function automatic logic [1:0] pick_op(int ins_w, int del_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_NONE;
    if (r < ins_w) return OP_INSERT;
    if (r < ins_w + del_w) return OP_DELETE;
    return OP_SEARCH;
  endfunction

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    op      = OP_SEARCH;
    key     = '0;
    idle_on = 1'b1;
    key_set[0] = 32'h8000_0000;
    key_set[1] = 32'h7FFF_FFFF;
    key_set[2] = 32'h0000_0000;
    key_set[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 320; i++) key_set[i] = $urandom;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_beat(OP_SEARCH, 32'h0);
    send_beat(OP_DELETE, 32'h5);
    send_beat(OP_INSERT, 32'h8000_0000);
    send_beat(OP_INSERT, 32'h7FFF_FFFF);
    send_beat(OP_INSERT, 32'h0);
    send_beat(OP_INSERT, 32'hFFFF_FFFF);
    send_beat(OP_INSERT, 32'h0000_0001);
    send_beat(OP_INSERT, 32'h7FFF_FFFF);
    send_beat(OP_SEARCH, 32'h8000_0000);
    send_beat(OP_SEARCH, 32'hFFFF_FFFF);
    send_beat(OP_SEARCH, 32'h0000_0002);
    send_beat(OP_NONE, 32'h0);
    send_beat(OP_NONE, 32'hFFFF_FFFF);
    send_beat(OP_DELETE, 32'h0000_0002);
    send_beat(OP_DELETE, 32'h8000_0000);
    send_beat(OP_DELETE, 32'h7FFF_FFFF);
    send_beat(OP_DELETE, 32'h0);
    send_beat(OP_DELETE, 32'hFFFF_FFFF);
    send_beat(OP_DELETE, 32'h0000_0001);
    send_beat(OP_SEARCH, 32'h0000_0001);
    send_beat(OP_INSERT, 32'h1234_5678);
    drain();

    for (int i = 0; i < 500; i++) send_beat(pick_op(50, 20), pick_key());
    for (int i = 0; i < 380; i++) send_beat(OP_INSERT, key_set[i % 320] ^ (i >= 320));
    for (int i = 0; i < 30; i++) send_beat(pick_op(60, 0), $urandom);
    drain();
    for (int i = 0; i < 450; i++) send_beat(pick_op(15, 55), pick_key());
    idle_on = 1'b0;
    for (int i = 0; i < 370; i++) send_beat(pick_op(40, 30), pick_key());
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sls_pkg.sv
design/sls_ctrl.sv
design/sls_dp.sv
design/skip_list_sorted_set_core.sv
design/sls_checker.sv
tb/sv/skip_list_sorted_set_checker.sv
tb/sv/testbench.sv
